[rtl/core/assert_macros.svh]
// assertion macros, included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[rtl/core/modexp_pkg.sv]
// types and constants of the modular exponentiation block
package modexp_pkg;

  localparam int WORD_BITS      = 32;
  localparam int CNT_BITS       = $clog2(WORD_BITS);
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = CFG_INDEX_BITS'(1);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_EXP,
    ST_DONE
  } state_t;

  // what a modular multiply is for, and where its product goes
  typedef enum logic [1:0] {
    KIND_RED,
    KIND_MUL,
    KIND_SQR
  } kind_t;

endpackage

[rtl/core/modexp_addmod.sv]
// modular adder: (x + y) mod m for x, y below m, without overflow
module modexp_addmod (
  input  modexp_pkg::word_t x,
  input  modexp_pkg::word_t y,
  input  modexp_pkg::word_t m,
  output modexp_pkg::word_t sum
);

  modexp_pkg::word_t gap;

  // distance of y to the modulus decides whether the sum wraps
  always_comb begin
    gap = m - y;
    if (x >= gap) begin
      sum = x - gap;
    end else begin
      sum = x + y;
    end
  end

endmodule

[rtl/core/modular_exponentiation.sv]
// top level of the modular exponentiation block
//
// Computes result = message ^ exponent mod modulus by right-to-left
// square-and-multiply. Every modular product runs bit-serially through one
// shared modular adder: one doubling step per multiplier bit plus one add
// step per set multiplier bit. A request first reduces the message by the
// modulus (one such product), then takes per exponent bit one squaring and
// one multiply when the bit is set, each after a pass through the
// sequencing state; the work stops after the highest set exponent bit.
// The block takes one request at a time and stalls its input meanwhile; the
// result sits in an output register, so the next request is taken while it
// waits. Modulus (index 0) and exponent (index 1) reset to 1; the user must
// write them only while no request is in flight, which the block itself does
// not enforce. A modulus of zero gives 0.
module modular_exponentiation (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  modexp_pkg::word_t                         message,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output modexp_pkg::word_t                         result,
  input  logic                                      cfg_write,
  input  logic [modexp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  modexp_pkg::word_t                         cfg_data
);

`include "assert_macros.svh"

  modexp_pkg::state_t              state;
  modexp_pkg::state_t              state_next;
  modexp_pkg::kind_t               kind;
  modexp_pkg::word_t               modulus;
  modexp_pkg::word_t               exponent;
  modexp_pkg::word_t               ebits;
  modexp_pkg::word_t               acc;
  modexp_pkg::word_t               pw;
  modexp_pkg::word_t               op_a;
  modexp_pkg::word_t               op_b;
  modexp_pkg::word_t               prod;
  modexp_pkg::word_t               add_y;
  modexp_pkg::word_t               add_sum;
  logic [modexp_pkg::CNT_BITS-1:0] bit_cnt;
  logic                            add_phase;
  logic                            mul_done;
  logic                            step_last;
  logic                            in_take;
  logic                            load_result;

  // shared modular adder: doubles the product or adds the multiplicand
  assign add_y = add_phase ? op_a : prod;

  modexp_addmod u_addmod (
    .x   (prod),
    .y   (add_y),
    .m   (modulus),
    .sum (add_sum)
  );

  // last cycle of a modular multiply
  assign step_last = (state == modexp_pkg::ST_MULT) && (bit_cnt == '0) &&
                     (add_phase || !op_b[modexp_pkg::WORD_BITS-1]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_valid) state_next = modexp_pkg::ST_MULT;
      end
      modexp_pkg::ST_MULT: begin
        if (step_last) state_next = modexp_pkg::ST_EXP;
      end
      modexp_pkg::ST_EXP: begin
        if (ebits == '0) begin
          state_next = modexp_pkg::ST_DONE;
        end else begin
          state_next = modexp_pkg::ST_MULT;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = modexp_pkg::ST_IDLE;
      end
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall    = (state != modexp_pkg::ST_IDLE);
    in_take     = in_valid && (state == modexp_pkg::ST_IDLE);
    load_result = (state == modexp_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::ST_IDLE;
      add_phase <= 1'b0;
      mul_done  <= 1'b0;
      out_valid <= 1'b0;
      modulus   <= modexp_pkg::word_t'(1);
      exponent  <= modexp_pkg::word_t'(1);
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          modexp_pkg::CFG_MODULUS:  modulus  <= cfg_data;
          modexp_pkg::CFG_EXPONENT: exponent <= cfg_data;
          default: ;
        endcase
      end
      // result register handshake
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // double then optionally add within a multiply
      if (state == modexp_pkg::ST_MULT) begin
        add_phase <= !add_phase && op_b[modexp_pkg::WORD_BITS-1];
      end else begin
        add_phase <= 1'b0;
      end
      // multiply for the current exponent bit already done
      if (in_take) begin
        mul_done <= 1'b0;
      end else if (step_last) begin
        mul_done <= (kind == modexp_pkg::KIND_MUL);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      modexp_pkg::ST_IDLE: begin
        // reduce the message first: message * 1 mod modulus
        if (in_valid) begin
          op_a    <= modexp_pkg::word_t'(1);
          op_b    <= message;
          prod    <= '0;
          kind    <= modexp_pkg::KIND_RED;
          bit_cnt <= modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);
          ebits   <= exponent;
          acc     <= (modulus == modexp_pkg::word_t'(1)) ? '0 : modexp_pkg::word_t'(1);
        end
      end
      modexp_pkg::ST_MULT: begin
        prod <= add_sum;
        if (add_phase || !op_b[modexp_pkg::WORD_BITS-1]) begin
          op_b    <= op_b << 1;
          bit_cnt <= bit_cnt - 1'b1;
        end
        // write the finished product back
        if (step_last) begin
          case (kind)
            modexp_pkg::KIND_RED: pw <= add_sum;
            modexp_pkg::KIND_MUL: acc <= add_sum;
            modexp_pkg::KIND_SQR: begin
              pw    <= add_sum;
              ebits <= ebits >> 1;
            end
            default: ;
          endcase
        end
      end
      modexp_pkg::ST_EXP: begin
        // multiply on a set bit, then square the base power
        prod    <= '0;
        bit_cnt <= modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);
        if (ebits[0] && !mul_done) begin
          kind <= modexp_pkg::KIND_MUL;
          op_a <= acc;
          op_b <= pw;
        end else begin
          kind <= modexp_pkg::KIND_SQR;
          op_a <= pw;
          op_b <= pw;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (load_result) begin
          result <= (modulus == '0) ? '0 : acc;
        end
      end
      default: ;
    endcase
  end

  // checks on the sequencer
  `ASSERT_AT(a_take_starts_mult, clk, rst, in_valid && !in_stall |=> state == modexp_pkg::ST_MULT)
  `ASSERT_AT(a_add_after_double, clk, rst, add_phase |-> $past(state == modexp_pkg::ST_MULT))
  `ASSERT_AT(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state == modexp_pkg::ST_DONE))
  `ASSERT_NEVER(a_exp_mid_product, clk, rst, state == modexp_pkg::ST_EXP && add_phase)

endmodule

[test/modular_exponentiation_test.sv]
// self-checking testbench of the modular exponentiation block
module modular_exponentiation_test;

  // register indexes that the block has no register for
  localparam logic [modexp_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO =
      modexp_pkg::CFG_INDEX_BITS'(2);
  localparam logic [modexp_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI =
      modexp_pkg::CFG_INDEX_BITS'(3);
  localparam int RANDOM_PHASES = 13;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    modexp_pkg::word_t message;
    modexp_pkg::word_t power;
  } expectation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  modexp_pkg::word_t message = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  modexp_pkg::word_t result;
  logic cfg_write = 1'b0;
  logic [modexp_pkg::CFG_INDEX_BITS-1:0] cfg_index = modexp_pkg::CFG_MODULUS;
  modexp_pkg::word_t cfg_data = '0;

  // key as the block should hold it
  modexp_pkg::word_t cur_modulus = modexp_pkg::word_t'(1);
  modexp_pkg::word_t cur_exponent = modexp_pkg::word_t'(1);

  int idle_pct = 0;
  int stall_pct = 0;
  modexp_pkg::word_t pending_messages[$];
  expectation_t expected_powers[$];
  int outstanding_requests = 0;
  int mismatches = 0;

  modular_exponentiation dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .message(message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // message ^ exponent mod modulus, square-and-multiply at double width
  function automatic modexp_pkg::word_t expected_power(modexp_pkg::word_t base);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m;
    if (cur_modulus == '0) return '0;
    m = 64'(cur_modulus);
    acc = 64'(1) % m;
    sq = 64'(base) % m;
    for (int b = 0; b < modexp_pkg::WORD_BITS; b++) begin
      if (cur_exponent[b]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return modexp_pkg::word_t'(acc);
  endfunction

  // message words around the interesting points of the current modulus
  function automatic modexp_pkg::word_t pick_message();
    case ($urandom_range(9))
      0: return '0;
      1: return modexp_pkg::word_t'(1);
      2: return cur_modulus - modexp_pkg::word_t'(1);
      3: return cur_modulus;
      4: return '1;
      5: return modexp_pkg::word_t'($urandom_range(255));
      default: return modexp_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic queue_message(modexp_pkg::word_t m);
    pending_messages.push_back(m);
    outstanding_requests++;
  endtask

  // wait until every queued request has come back
  task automatic drain();
    while (outstanding_requests != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [modexp_pkg::CFG_INDEX_BITS-1:0] index,
                                modexp_pkg::word_t data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      modexp_pkg::CFG_MODULUS: cur_modulus = data;
      modexp_pkg::CFG_EXPONENT: cur_exponent = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // idling modes: none, sender idle, receiver stalling, both
  task automatic set_idling(int mode);
    case (mode)
      1: begin
        idle_pct = 81;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 81;
      end
      3: begin
        idle_pct = 13;
        stall_pct = 13;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // driver: record accepted requests, then offer the next pending one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_powers.push_back(expectation_t'{message, expected_power(message)});
      end
      if (!in_valid || !in_stall) begin
        if (pending_messages.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          message <= pending_messages.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    expectation_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %h with no request pending", result);
        end else begin
          want = expected_powers.pop_front();
          outstanding_requests--;
          if (result !== want.power) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("message %h: expected %h, got %h", want.message, want.power, result);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // stimulus
  initial begin
    modexp_pkg::word_t n;
    modexp_pkg::word_t e;
    int count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // key as left by reset: modulus of one
    queue_message('0);
    queue_message('1);
    drain();

    // zero exponent with the largest modulus
    write_register(modexp_pkg::CFG_MODULUS, '1);
    write_register(modexp_pkg::CFG_EXPONENT, '0);
    queue_message('0);
    queue_message(modexp_pkg::word_t'(1));
    queue_message('1);
    queue_message(modexp_pkg::word_t'($urandom));
    drain();

    // full exponent, message at and just below the modulus
    write_register(modexp_pkg::CFG_EXPONENT, '1);
    queue_message('0);
    queue_message(modexp_pkg::word_t'(1));
    queue_message(modexp_pkg::word_t'(2));
    queue_message('1);
    queue_message('1 - modexp_pkg::word_t'(1));
    drain();

    // modulus of zero answers zero
    write_register(modexp_pkg::CFG_MODULUS, '0);
    write_register(modexp_pkg::CFG_EXPONENT, modexp_pkg::word_t'(65537));
    queue_message(modexp_pkg::word_t'(5));
    queue_message('1);
    drain();

    // small textbook key, messages below, at and above the modulus
    write_register(modexp_pkg::CFG_MODULUS, modexp_pkg::word_t'(3233));
    write_register(modexp_pkg::CFG_EXPONENT, modexp_pkg::word_t'(17));
    queue_message(modexp_pkg::word_t'(65));
    queue_message(modexp_pkg::word_t'(3233));
    queue_message(modexp_pkg::word_t'(3234));
    queue_message('1);
    drain();

    // writes to unknown indexes leave the key alone
    write_register(modexp_pkg::CFG_MODULUS, modexp_pkg::word_t'(2));
    write_register(CFG_SPARE_LO, modexp_pkg::word_t'($urandom));
    write_register(modexp_pkg::CFG_EXPONENT, modexp_pkg::word_t'(3));
    write_register(CFG_SPARE_HI, modexp_pkg::word_t'($urandom));
    queue_message(modexp_pkg::word_t'(3));
    queue_message(modexp_pkg::word_t'(2));
    queue_message(modexp_pkg::word_t'($urandom));
    drain();

    // random keys, mostly short exponents, a few full-length ones
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(p % 4);
      case ($urandom_range(9))
        0: n = modexp_pkg::word_t'(1);
        1: n = '1;
        2: n = '0;
        3, 4: n = modexp_pkg::word_t'($urandom_range(255, 2));
        default: n = modexp_pkg::word_t'($urandom);
      endcase
      if (p % 6 == 5) begin
        e = modexp_pkg::word_t'($urandom) | {1'b1, {(modexp_pkg::WORD_BITS-1){1'b0}}};
        count = 4;
      end else begin
        e = modexp_pkg::word_t'($urandom) &
            modexp_pkg::word_t'((64'(1) << $urandom_range(10)) - 1);
        count = 24;
      end
      if ($urandom_range(1))
        write_register($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                       modexp_pkg::word_t'($urandom));
      write_register(modexp_pkg::CFG_MODULUS, n);
      write_register(modexp_pkg::CFG_EXPONENT, e);
      repeat (count) queue_message(pick_message());
      drain();
    end

    // let any stray result show up
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
